### rtl/ncv_pkg.sv
// shared types, constants and helper functions for the normalized 3x3 convolution
`timescale 1ns / 1ps
`default_nettype none
package ncv_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W  = 11;
   localparam int CNT_W  = 21;
   localparam int IDX_W  = $clog2(MAX_WIDTH);
   localparam int WORD_W = 32;
   localparam int KROW_W = 24;
   localparam int ACC_W  = 20;
   localparam int MAG_W  = 19;
   localparam int KS_W   = 12;
   localparam int DMAG_W = 11;
   localparam int POS_W  = 12;
   localparam int TAP_W  = 4;
   localparam int NTAPS  = 9;
   localparam int STEP_W = 5;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_KTOP   = 3'd0;
   localparam logic [2:0] REG_KMID   = 3'd1;
   localparam logic [2:0] REG_KBOT   = 3'd2;
   localparam logic [2:0] REG_WIDTH  = 3'd3;
   localparam logic [2:0] REG_HEIGHT = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TDIV,
      ST_READ,
      ST_UPDATE,
      ST_TAP,
      ST_DINIT,
      ST_CDIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             load;
      logic             tdiv_step;
      logic             read;
      logic             update;
      logic             tap_step;
      logic [TAP_W-1:0] tap_idx;
      logic             dinit;
      logic             cdiv_step;
      logic             out_load;
   } cmd_type;

   typedef struct packed {
      logic produce;
      logic ksum_zero;
   } status_type;

   function automatic logic [1:0] tap_row(input logic [TAP_W-1:0] idx);
      logic [1:0] r;
      unique case (idx)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] tap_col(input logic [TAP_W-1:0] idx);
      logic [1:0] c;
      unique case (idx)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic signed [7:0] tap_coef(input logic [KROW_W-1:0] ktop,
                                                  input logic [KROW_W-1:0] kmid,
                                                  input logic [KROW_W-1:0] kbot,
                                                  input logic [TAP_W-1:0]  idx);
      logic [KROW_W-1:0] row;
      logic [7:0]        b;
      unique case (tap_row(idx))
         2'd0:    row = ktop;
         2'd1:    row = kmid;
         default: row = kbot;
      endcase
      unique case (tap_col(idx))
         2'd0:    b = row[7:0];
         2'd1:    b = row[15:8];
         default: b = row[23:16];
      endcase
      return signed'(b);
   endfunction

endpackage
`default_nettype wire

### rtl/ncv_if.sv
// pixel and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ncv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan_zero;
   logic [7:0] chan_one;
   logic [7:0] chan_two;
   logic [7:0] spare_byte;
   logic       flush;
   modport source (output valid, chan_zero, chan_one, chan_two, spare_byte, flush,
                   input ready);
   modport sink (input valid, chan_zero, chan_one, chan_two, spare_byte, flush,
                 output ready);
endinterface

interface ncv_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_zero;
   logic [7:0] out_one;
   logic [7:0] out_two;
   logic [7:0] out_spare;
   logic       frame_last;
   modport source (output valid, out_zero, out_one, out_two, out_spare, frame_last,
                   input ready);
   modport sink (input valid, out_zero, out_one, out_two, out_spare, frame_last,
                 output ready);
endinterface
`default_nettype wire

### rtl/ncv_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ncv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### rtl/ncv_ctrl.sv
// sequencing state machine for one pixel beat
`timescale 1ns / 1ps
`default_nettype none
module ncv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  ncv_pkg::status_type status,
   output ncv_pkg::cmd_type    cmd
);
   import ncv_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_TDIV;
            end
         end
         ST_TDIV: begin
            cmd.tdiv_step = 1'b1;
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               step_in  = '0;
               state_in = ST_READ;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            step_in    = '0;
            state_in   = status.produce ? ST_TAP : ST_IDLE;
         end
         ST_TAP: begin
            cmd.tap_step = 1'b1;
            cmd.tap_idx  = step_ff[TAP_W-1:0];
            if (step_ff == STEP_W'(NTAPS - 1)) begin
               step_in  = '0;
               state_in = ST_DINIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DINIT: begin
            cmd.dinit = 1'b1;
            step_in   = '0;
            state_in  = status.ksum_zero ? ST_FINISH : ST_CDIV;
         end
         ST_CDIV: begin
            cmd.cdiv_step = 1'b1;
            if (step_ff == STEP_W'(MAG_W - 1)) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

### rtl/ncv_datapath.sv
// line buffers, window, tap accumulators, dividers and result registers
`timescale 1ns / 1ps
`default_nettype none
module ncv_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  ncv_pkg::cmd_type            cmd,
   output ncv_pkg::status_type         status,
   input  logic [ncv_pkg::KROW_W-1:0]  kernel_top_row,
   input  logic [ncv_pkg::KROW_W-1:0]  kernel_mid_row,
   input  logic [ncv_pkg::KROW_W-1:0]  kernel_bottom_row,
   input  logic [ncv_pkg::DIM_W-1:0]   frame_width,
   input  logic [ncv_pkg::DIM_W-1:0]   frame_height,
   input  logic [7:0]                  chan_zero,
   input  logic [7:0]                  chan_one,
   input  logic [7:0]                  chan_two,
   input  logic [7:0]                  spare_byte,
   input  logic                        flush,
   output logic [7:0]                  out_zero,
   output logic [7:0]                  out_one,
   output logic [7:0]                  out_two,
   output logic [7:0]                  out_spare,
   output logic                        frame_last
);
   import ncv_pkg::*;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] word_ff;
   logic [DIM_W-1:0]  w_ff, h_ff, w_clamp, h_clamp;
   logic [CNT_W-1:0]  n_ff, t_ff;
   logic [CNT_W-1:0]  tq_ff;
   logic [DIM_W-1:0]  tr_ff;
   logic [DIM_W:0]    tsh;
   logic              tge;
   logic              produce_ff, last_ff;
   logic signed [POS_W-1:0] prow_ff, pcol_ff;
   logic [WORD_W-1:0] win_ff [NTAPS];
   logic [WORD_W-1:0] mid_rd, top_rd;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [KS_W-1:0]  ksum_ff;
   logic [MAG_W-1:0]  dq_ff [3];
   logic [DMAG_W-1:0] drem_ff [3];
   logic              neg_ff [3];
   logic [DMAG_W-1:0] dvs_ff;
   logic signed [7:0] kcoef;
   logic [WORD_W-1:0] tap_word;
   logic signed [POS_W-1:0] rr, cc;
   logic              tap_in;
   logic [7:0]        res [3];
   logic [7:0]        out_ff [3];
   logic [7:0]        spare_ff;
   logic              last_out_ff;

   ncv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_mid_row (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (tr_ff[IDX_W-1:0]),
      .wr_data (word_ff),
      .rd_addr (tr_ff[IDX_W-1:0]),
      .rd_data (mid_rd)
   );

   ncv_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_top_row (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (tr_ff[IDX_W-1:0]),
      .wr_data (mid_rd),
      .rd_addr (tr_ff[IDX_W-1:0]),
      .rd_data (top_rd)
   );

   always_comb begin
      if (frame_width == '0) begin
         w_clamp = DIM_W'(1);
      end else if (int'(frame_width) > MAX_WIDTH) begin
         w_clamp = DIM_W'(MAX_WIDTH);
      end else begin
         w_clamp = frame_width;
      end
      if (frame_height == '0) begin
         h_clamp = DIM_W'(1);
      end else if (int'(frame_height) > MAX_HEIGHT) begin
         h_clamp = DIM_W'(MAX_HEIGHT);
      end else begin
         h_clamp = frame_height;
      end
   end

   assign tsh = {tr_ff, tq_ff[CNT_W-1]};
   assign tge = tsh >= {1'b0, w_ff};

   always_comb begin
      if (t_ff >= (n_ff + CNT_W'(w_ff))) begin
         cnt_in = '0;
      end else begin
         cnt_in = t_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.read) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= top_rd;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= mid_rd;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= word_ff;
      end
   end

   assign kcoef    = tap_coef(kernel_top_row, kernel_mid_row, kernel_bottom_row, cmd.tap_idx);
   assign tap_word = win_ff[cmd.tap_idx];
   assign rr       = prow_ff + POS_W'(tap_row(cmd.tap_idx)) - POS_W'(1);
   assign cc       = pcol_ff + POS_W'(tap_col(cmd.tap_idx)) - POS_W'(1);
   assign tap_in   = (rr >= 0) && (rr < signed'({1'b0, h_ff}))
                  && (cc >= 0) && (cc < signed'({1'b0, w_ff}));

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (ksum_ff == '0) begin
            if (acc_ff[c] < 0) begin
               res[c] = 8'd0;
            end else if (acc_ff[c] > ACC_W'(255)) begin
               res[c] = 8'd255;
            end else begin
               res[c] = acc_ff[c][7:0];
            end
         end else if (neg_ff[c]) begin
            res[c] = 8'd0;
         end else if (dq_ff[c] > MAG_W'(255)) begin
            res[c] = 8'd255;
         end else begin
            res[c] = dq_ff[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= flush ? '0 : {spare_byte, chan_two, chan_one, chan_zero};
         w_ff    <= w_clamp;
         h_ff    <= h_clamp;
         n_ff    <= CNT_W'(w_clamp) * CNT_W'(h_clamp);
         t_ff    <= cnt_ff;
         tq_ff   <= cnt_ff;
         tr_ff   <= '0;
      end
      if (cmd.tdiv_step) begin
         tq_ff <= {tq_ff[CNT_W-2:0], tge};
         tr_ff <= tge ? DIM_W'(tsh - {1'b0, w_ff}) : tsh[DIM_W-1:0];
      end
      if (cmd.read) begin
         produce_ff <= (t_ff >= (CNT_W'(w_ff) + 1'b1))
                    && (t_ff < (n_ff + CNT_W'(w_ff) + 1'b1));
         last_ff    <= t_ff == (n_ff + CNT_W'(w_ff));
         prow_ff    <= (tr_ff != '0) ? POS_W'(tq_ff - 1'b1) : POS_W'(tq_ff - CNT_W'(2));
         pcol_ff    <= (tr_ff != '0) ? POS_W'(tr_ff - 1'b1) : POS_W'(w_ff - 1'b1);
      end
      if (cmd.update) begin
         ksum_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= '0;
         end
      end
      if (cmd.tap_step) begin
         ksum_ff <= ksum_ff + KS_W'(kcoef);
         for (int c = 0; c < 3; c++) begin
            if (tap_in) begin
               acc_ff[c] <= acc_ff[c]
                  + ACC_W'(kcoef * signed'({1'b0, tap_word[8*c +: 8]}));
            end
         end
      end
      if (cmd.dinit) begin
         dvs_ff <= (ksum_ff < 0) ? DMAG_W'(-ksum_ff) : DMAG_W'(ksum_ff);
         for (int c = 0; c < 3; c++) begin
            dq_ff[c]   <= (acc_ff[c] < 0) ? MAG_W'(-acc_ff[c]) : MAG_W'(acc_ff[c]);
            drem_ff[c] <= '0;
            neg_ff[c]  <= (acc_ff[c] != '0) && ((acc_ff[c] < 0) != (ksum_ff < 0));
         end
      end
      if (cmd.cdiv_step) begin
         for (int c = 0; c < 3; c++) begin
            if ({drem_ff[c], dq_ff[c][MAG_W-1]} >= {1'b0, dvs_ff}) begin
               drem_ff[c] <= DMAG_W'({drem_ff[c], dq_ff[c][MAG_W-1]} - {1'b0, dvs_ff});
               dq_ff[c]   <= {dq_ff[c][MAG_W-2:0], 1'b1};
            end else begin
               drem_ff[c] <= {drem_ff[c][DMAG_W-2:0], dq_ff[c][MAG_W-1]};
               dq_ff[c]   <= {dq_ff[c][MAG_W-2:0], 1'b0};
            end
         end
      end
      if (cmd.out_load) begin
         for (int c = 0; c < 3; c++) begin
            out_ff[c] <= res[c];
         end
         spare_ff    <= win_ff[4][31:24];
         last_out_ff <= last_ff;
      end
   end

   assign status.produce   = produce_ff;
   assign status.ksum_zero = ksum_ff == '0;

   assign out_zero   = out_ff[0];
   assign out_one    = out_ff[1];
   assign out_two    = out_ff[2];
   assign out_spare  = spare_ff;
   assign frame_last = last_out_ff;
endmodule
`default_nettype wire

### rtl/normalized_3x3_convolution.sv
// top level: register port, controller and datapath of the 3x3 convolution
`timescale 1ns / 1ps
`default_nettype none
// Streams pixels and returns one filtered pixel per input beat once the window is full:
// the result for pixel p comes out with input beat p+W+1, so after each frame the host
// sends W+1 flush beats. Every beat runs the bit-serial position divider (21 steps); a
// beat that yields a result also runs the nine-tap multiply-accumulate loop and then the
// bit-serial normalizing divider (19 steps), which is skipped when the kernel coefficients
// sum to zero. A beat that yields a result can also be held while an unaccepted earlier
// result holds the output register. A finished result waits in the output register while
// the next beat is taken. The host must write the kernel and geometry registers over the
// APB port only while the block is idle; the block itself does not enforce this. There is
// no clearing pass after reset.
module normalized_3x3_convolution (
   input  logic                       clock,
   input  logic                       reset,
   ncv_req_if.sink                    req,
   ncv_rsp_if.source                  rsp,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ncv_pkg::ADDR_W-1:0] paddr,
   input  logic [ncv_pkg::DATA_W-1:0] pwdata,
   output logic [ncv_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import ncv_pkg::*;

   logic [KROW_W-1:0] ktop_ff, kmid_ff, kbot_ff;
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [2:0]        reg_idx;
   logic              wr_en;
   cmd_type           cmd;
   status_type        status;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ktop_ff   <= '0;
         kmid_ff   <= KROW_W'(256);
         kbot_ff   <= '0;
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_KTOP:   ktop_ff   <= pwdata[KROW_W-1:0];
            REG_KMID:   kmid_ff   <= pwdata[KROW_W-1:0];
            REG_KBOT:   kbot_ff   <= pwdata[KROW_W-1:0];
            REG_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_KTOP:   prdata = DATA_W'(ktop_ff);
         REG_KMID:   prdata = DATA_W'(kmid_ff);
         REG_KBOT:   prdata = DATA_W'(kbot_ff);
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   ncv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .status    (status),
      .cmd       (cmd)
   );

   ncv_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .kernel_top_row    (ktop_ff),
      .kernel_mid_row    (kmid_ff),
      .kernel_bottom_row (kbot_ff),
      .frame_width       (width_ff),
      .frame_height      (height_ff),
      .chan_zero         (req.chan_zero),
      .chan_one          (req.chan_one),
      .chan_two          (req.chan_two),
      .spare_byte        (req.spare_byte),
      .flush             (req.flush),
      .out_zero          (rsp.out_zero),
      .out_one           (rsp.out_one),
      .out_two           (rsp.out_two),
      .out_spare         (rsp.out_spare),
      .frame_last        (rsp.frame_last)
   );

   a_one_beat_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("input taken while a beat is in progress");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> !$past(req.ready))
      else $error("result raised without a beat in progress");

   a_load_not_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !req.ready)
      else $error("result loaded while idle");
endmodule
`default_nettype wire
